// ----- rtl/sapq_pkg.sv -----
// sapq_pkg: shared types and codes for the sorted-array priority queue
`default_nettype none

package sapq_pkg;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] value;
  } sapq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [6:0]         occupancy;
  } sapq_rsp_t;

  // command broadcast to every cell in the row
  typedef struct packed {
    logic               en;
    logic               mode;
    logic signed [31:0] value;
  } sapq_cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_array_priority_queue_core.sv -----
// sorted_array_priority_queue_core: min-priority queue built as a row of sorting cells
`default_nettype none

// Usage
//   Input: raise start with request (mode, value) while busy is low; the word
//   is taken at that edge. mode insert places value behind every stored key
//   not greater than it; mode remove takes out the smallest (oldest of equals).
//   Output: one result word per request, shown on result for exactly one
//   cycle with done high, the cycle after the request was taken.
//   One request is taken every cycle: every cell of the row compares its
//   key with the incoming value and shifts to or from its neighbour in the
//   same cycle, so busy never rises.
//   An insert into a full queue returns overflow and a remove from an empty
//   queue returns underflow; neither changes the stored keys.
//   occupancy is the entry count after the operation, truncated to 7 bits.
//   Reset (rst, synchronous) empties the queue at once; no clearing pass is
//   needed because slots at or above the count are never read.
//   The receiver cannot stall; result words must be taken as they appear.

module sorted_array_priority_queue_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire sapq_pkg::sapq_req_t request,
  output logic                     busy,
  output logic                     done,
  output sapq_pkg::sapq_rsp_t      result
);
  import sapq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               full;
  logic               empty;
  logic               op_ok;
  sapq_cell_cmd_t     cell_cmd;
  logic               gt   [CAPACITY];
  logic signed [31:0] keys [CAPACITY];

  assign busy  = 1'b0;
  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);
  assign op_ok = (request.mode == MODE_REMOVE) ? !empty : !full;

  assign cell_cmd.en    = start && op_ok;
  assign cell_cmd.mode  = request.mode;
  assign cell_cmd.value = request.value;

  always_comb begin
    count_next = count;
    if (start && op_ok) begin
      if (request.mode == MODE_REMOVE) begin
        count_next = count - CW'(1);
      end else begin
        count_next = count + CW'(1);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               occ;
    logic               pgt;
    logic signed [31:0] pkey;
    logic signed [31:0] nkey;

    assign occ = (CW'(i) < count);

    if (i == 0) begin : g_first
      assign pgt  = 1'b0;
      assign pkey = keys[i];
    end else begin : g_mid
      assign pgt  = gt[i-1];
      assign pkey = keys[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign nkey = keys[i];
    end else begin : g_inner
      assign nkey = keys[i+1];
    end

    sapq_cell u_cell (
      .clk      (clk),
      .cmd      (cell_cmd),
      .occupied (occ),
      .prev_gt  (pgt),
      .prev_key (pkey),
      .next_key (nkey),
      .gt       (gt[i]),
      .key      (keys[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= start;
    end
  end

  // result word, payload needs no reset
  always_ff @(posedge clk) begin
    if (start) begin
      result.occupancy <= 7'(count_next);
      if (request.mode == MODE_REMOVE) begin
        if (empty) begin
          result.status        <= STATUS_UNDERFLOW;
          result.removed_value <= '0;
        end else begin
          result.status        <= STATUS_OK;
          result.removed_value <= keys[0];
        end
      end else begin
        result.status        <= full ? STATUS_OVERFLOW : STATUS_OK;
        result.removed_value <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sapq_cell.sv -----
// sapq_cell: one slot of the sorted row, holds a key and trades with its neighbours
`default_nettype none

module sapq_cell (
  input  wire logic                    clk,
  input  wire sapq_pkg::sapq_cell_cmd_t cmd,
  input  wire logic                    occupied,
  input  wire logic                    prev_gt,
  input  wire logic signed [31:0]      prev_key,
  input  wire logic signed [31:0]      next_key,
  output logic                         gt,
  output logic signed [31:0]           key
);
  import sapq_pkg::*;

  logic signed [31:0] key_next;

  // empty slots count as greater so the row stays monotone
  assign gt = !occupied || (key > cmd.value);

  always_comb begin
    if (cmd.mode == MODE_REMOVE) begin
      key_next = next_key;
    end else if (prev_gt) begin
      key_next = prev_key;
    end else if (gt) begin
      key_next = cmd.value;
    end else begin
      key_next = key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      key <= key_next;
    end
  end

endmodule

`default_nettype wire
